// ----- src/bspu_pkg.sv -----
// bspu_pkg: shared types, sizes and status codes of the bit stream packer/unpacker
// depends on nothing; imported by the top level and its checker
package bspu_pkg;

  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CUR_W       = $clog2(STORE_BYTES * 8 + 1);
  localparam int LEN_W       = 11;
  localparam int VAL_W       = 64;
  localparam int CNT_W       = 7;
  localparam int WIN_W       = VAL_W + 8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_NO_DATA   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic signed [VAL_W-1:0] write_value;
    logic [CNT_W-1:0]        bit_count;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [LEN_W-1:0]        length_bytes;
  } out_t;

endpackage

// ----- src/bit_stream_packer_unpacker.sv -----
// bit_stream_packer_unpacker: msb-first bit writer and reader over a byte store
// depends on bspu_pkg
//
// Write transactions append the low bit_count (1..64) bits of write_value at the
// write cursor, first bit into bit 7 of each byte; read transactions take
// bit_count bits from an independent read cursor and return them sign-extended.
// Each transaction yields one result carrying status and the written length in
// bytes. One transaction is in flight at a time: in_ready is high only while the
// sequencer idles. A write stores nb bytes and a read fetches nb bytes, where
// nb = ceil((cursor bit offset + bit_count) / 8) is at most 9; the store has
// one byte port each way and is walked one byte per cycle. Refused transactions
// go straight to the result. A result parked in the output register does not
// block acceptance of the next transaction. No clearing pass follows reset:
// bytes wholly beyond the write cursor are never read and are written as fresh
// bytes, so the store reads as cleared from the first cycle.
module bit_stream_packer_unpacker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bspu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bspu_pkg::out_t out_data
);
  import bspu_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WR    = 6'b000010,
    S_RD    = 6'b000100,
    S_ALIGN = 6'b001000,
    S_SEXT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // cursors, reset to zero
  logic [CUR_W-1:0] wc_r, wc_nxt;
  logic [CUR_W-1:0] rc_r, rc_nxt;

  // per-transaction working registers
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [2:0]        off_r, off_nxt;
  logic [3:0]        nb_r, nb_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              first_r, first_nxt;
  logic              pend_r, pend_nxt;
  logic [WIN_W-1:0]  acc_r, acc_nxt;
  logic [7:0]        tail_r, tail_nxt;
  logic [VAL_W-1:0]  res_r, res_nxt;
  logic [1:0]        status_r, status_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // byte store
  logic [7:0]        mem [STORE_BYTES];
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [7:0]        rd_data_r;

  // shared barrel shifter: logical left or arithmetic right
  logic              sh_left;
  logic [WIN_W-1:0]  sh_in;
  logic [6:0]        sh_amt;
  logic [WIN_W-1:0]  sh_out;

  // acceptance checks
  logic [CUR_W:0]    wr_end, rd_end, wc_round;
  logic [CUR_W-3:0]  wr_need, rd_need, filled;
  logic [7:0]        nb_sum;
  logic [2:0]        in_off;
  logic              bad_count, wr_full, rd_short;
  logic [VAL_W-1:0]  val_mask;
  logic [7:0]        amt_full;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (sh_left) begin
      sh_out = sh_in << sh_amt;
    end else begin
      sh_out = $signed(sh_in) >>> sh_amt;
    end
  end

  // checks on the incoming transaction
  always_comb begin
    in_off    = (in_data.cmd == CMD_WRITE) ? wc_r[2:0] : rc_r[2:0];
    bad_count = (in_data.bit_count == '0) || (in_data.bit_count > CNT_W'(VAL_W));
    wr_end    = {1'b0, wc_r} + (CUR_W+1)'(in_data.bit_count) + (CUR_W+1)'(7);
    rd_end    = {1'b0, rc_r} + (CUR_W+1)'(in_data.bit_count) + (CUR_W+1)'(7);
    wc_round  = {1'b0, wc_r} + (CUR_W+1)'(7);
    wr_need   = wr_end[CUR_W:3];
    rd_need   = rd_end[CUR_W:3];
    filled    = wc_round[CUR_W:3];
    wr_full   = (wr_need > (CUR_W-2)'(STORE_BYTES));
    rd_short  = (rd_need > filled);
    nb_sum    = {5'b0, in_off} + {1'b0, in_data.bit_count} + 8'd7;
    // keep only the low bit_count bits of the value
    val_mask  = ~({VAL_W{1'b1}} << in_data.bit_count);
    amt_full  = 8'(WIN_W) - {5'b0, in_off} - {1'b0, in_data.bit_count};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wc_nxt        = wc_r;
    rc_nxt        = rc_r;
    count_nxt     = count_r;
    off_nxt       = off_r;
    nb_nxt        = nb_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    first_nxt     = first_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    tail_nxt      = tail_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    sh_left       = 1'b1;
    sh_in         = {8'b0, in_data.write_value & val_mask};
    sh_amt        = amt_full[6:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          count_nxt  = in_data.bit_count;
          off_nxt    = in_off;
          nb_nxt     = nb_sum[6:3];
          cnt_nxt    = '0;
          first_nxt  = 1'b1;
          pend_nxt   = 1'b0;
          res_nxt    = '0;
          status_nxt = ST_OK;
          if (bad_count) begin
            status_nxt = ST_BAD_COUNT;
            state_nxt  = S_OUT;
          end else if (in_data.cmd == CMD_WRITE) begin
            if (wr_full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_OUT;
            end else begin
              // value placed so its first bit sits at the cursor offset of the top byte
              acc_nxt   = sh_out;
              addr_nxt  = wc_r[ADDR_W+2:3];
              state_nxt = S_WR;
            end
          end else begin
            if (rd_short) begin
              status_nxt = ST_NO_DATA;
              state_nxt  = S_OUT;
            end else begin
              addr_nxt  = rc_r[ADDR_W+2:3];
              state_nxt = S_RD;
            end
          end
        end
      end

      S_WR: begin
        // a partly filled first byte merges with the tail byte, later bytes are fresh
        mem_we    = 1'b1;
        mem_wdata = acc_r[WIN_W-1 -: 8] | ((first_r && (off_r != '0)) ? tail_r : 8'h00);
        tail_nxt  = mem_wdata;
        acc_nxt   = acc_r << 8;
        addr_nxt  = addr_r + ADDR_W'(1);
        cnt_nxt   = cnt_r + 4'd1;
        first_nxt = 1'b0;
        if (cnt_r == nb_r - 4'd1) begin
          wc_nxt    = wc_r + CUR_W'(count_r);
          state_nxt = S_OUT;
        end
      end

      S_RD: begin
        // issue one byte address a cycle, collect its registered data in the cycle after
        if (cnt_r != nb_r) begin
          mem_re   = 1'b1;
          addr_nxt = addr_r + ADDR_W'(1);
          cnt_nxt  = cnt_r + 4'd1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          acc_nxt = {acc_r[WIN_W-9:0], rd_data_r};
        end
        if ((cnt_r == nb_r) && !pend_r) begin
          state_nxt = S_ALIGN;
        end
      end

      S_ALIGN: begin
        // first wanted bit to the top of the window
        sh_in     = acc_r;
        sh_amt    = 7'(8'(WIN_W) - {1'b0, nb_r, 3'b0} + {5'b0, off_r});
        acc_nxt   = sh_out;
        state_nxt = S_SEXT;
      end

      S_SEXT: begin
        // arithmetic right shift drops the excess bits and sign-extends
        sh_left   = 1'b0;
        sh_in     = {acc_r[WIN_W-1:8], 8'b0};
        sh_amt    = 7'(VAL_W) - count_r;
        res_nxt   = sh_out[WIN_W-1:8];
        rc_nxt    = rc_r + CUR_W'(count_r);
        state_nxt = S_OUT;
      end

      S_OUT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.read_value   = res_r;
          out_data_nxt.status       = status_r;
          out_data_nxt.length_bytes = filled[LEN_W-1:0];
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wc_r        <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      rc_r        <= rc_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    off_r      <= off_nxt;
    nb_r       <= nb_nxt;
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    first_r    <= first_nxt;
    acc_r      <= acc_nxt;
    tail_r     <= tail_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[addr_r];
    end
  end

endmodule

// ----- src/bspu_checker.sv -----
// bspu_checker: port-level assertions for the bit stream packer/unpacker
// depends on bspu_pkg; bound to bit_stream_packer_unpacker below
module bspu_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input bspu_pkg::out_t out_data
);
  import bspu_pkg::*;

  // a parked result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one transaction in flight: ready drops after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while busy");

  // refused transactions return zero
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.read_value == '0)
    else $error("nonzero value on a refused transaction");

  // written length never exceeds the store
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.length_bytes <= LEN_W'(STORE_BYTES))
    else $error("length beyond store size");

endmodule

bind bit_stream_packer_unpacker bspu_checker u_bspu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
